>>> design/modexp_pkg.sv
package modexp_pkg;

    localparam int BASE_BITS     = 63;
    localparam int EXPONENT_BITS = 63;
    localparam int MODULUS_BITS  = 31;

    localparam int IN_DATA_W  = ((BASE_BITS + EXPONENT_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((MODULUS_BITS + 7) / 8) * 8;

    localparam int SCAN_BITS  = (BASE_BITS > EXPONENT_BITS) ? BASE_BITS : EXPONENT_BITS;
    localparam int SCAN_CNT_W = $clog2(SCAN_BITS);
    localparam int MUL_CNT_W  = (MODULUS_BITS > 1) ? $clog2(MODULUS_BITS) : 1;

    localparam logic [MODULUS_BITS-1:0] MODULUS_RESET = MODULUS_BITS'(64'd1000000007);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_DONE
    } modexp_state_t;

endpackage

>>> design/modular_exponentiation_unit.sv
// Modular exponentiation, base^exponent mod modulus, by left-to-right square-and-multiply.
// With a nonzero modulus an item holds the block from its accept to the earliest next
// accept: base_value is first reduced one bit per cycle in ST_REDUCE, then all 63
// exponent bits are scanned, each costing a modular square plus a modular multiply when
// the bit is set; the result is then registered in ST_DONE and the input reopens in
// ST_IDLE. The single bit-serial multiply/reduce unit (one multiplier bit per cycle)
// does every square and multiply. One item is worked on at a time; the next may be
// accepted while the previous result still waits on the output, and a finished result
// waits until the output frees. A modulus of 0 skips reduction and scanning and returns
// 0 through ST_DONE. The user must write the modulus via cfg_we/cfg_wdata only while
// the block is idle; the block does not enforce this. The modulus resets to 1000000007.
module modular_exponentiation_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [modexp_pkg::MODULUS_BITS-1:0]    cfg_wdata,   // modulus
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [modexp_pkg::IN_DATA_W-1:0]       s_tdata,     // base_value, exponent
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [modexp_pkg::OUT_DATA_W-1:0]      m_tdata      // power_residue
);

    localparam int MB = modexp_pkg::MODULUS_BITS;
    localparam int BB = modexp_pkg::BASE_BITS;
    localparam int EB = modexp_pkg::EXPONENT_BITS;
    localparam int SW = modexp_pkg::SCAN_CNT_W;
    localparam int MW = modexp_pkg::MUL_CNT_W;

    modexp_pkg::modexp_state_t state_reg, state_next;

    logic [MB-1:0] modulus_reg;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [MB-1:0] res_reg, res_next;
    logic [BB-1:0] base_sr_reg, base_sr_next;
    logic [EB-1:0] exp_sr_reg, exp_sr_next;
    logic [MB-1:0] base_red_reg, base_red_next;
    logic [MB-1:0] acc_reg, acc_next;
    logic [MB-1:0] work_reg, work_next;
    logic [MB-1:0] mul_a_reg, mul_a_next;
    logic [MB-1:0] mul_b_reg, mul_b_next;
    logic [SW-1:0] scan_cnt_reg, scan_cnt_next;
    logic [MW-1:0] mul_cnt_reg, mul_cnt_next;

    logic [MB-1:0] red_step;
    logic [MB-1:0] mul_step;
    logic [MB-1:0] acc_init;

    // one bit of a long division remainder: r < m in, r < m out
    function automatic logic [MB-1:0] reduce_step(input logic [MB-1:0] r, input logic b,
                                                  input logic [MB-1:0] m);
        logic [MB:0] s;
        logic [MB:0] mx;
        begin
            s  = {r, b};
            mx = {1'b0, m};
            if (s >= mx)
            begin
                s = s - mx;
            end
            reduce_step = s[MB-1:0];
        end
    endfunction

    // one step of interleaved modular multiply: (2r + b*a) mod m, sum < 3m
    function automatic logic [MB-1:0] mulred_step(input logic [MB-1:0] r, input logic b,
                                                  input logic [MB-1:0] a,
                                                  input logic [MB-1:0] m);
        logic [MB+1:0] s;
        logic [MB+1:0] m1;
        logic [MB+1:0] m2;
        begin
            m1 = {2'b00, m};
            m2 = {1'b0, m, 1'b0};
            s  = {1'b0, r, 1'b0} + (b ? {2'b00, a} : '0);
            if (s >= m2)
            begin
                s = s - m2;
            end
            else if (s >= m1)
            begin
                s = s - m1;
            end
            mulred_step = s[MB-1:0];
        end
    endfunction

    assign red_step = reduce_step(base_red_reg, base_sr_reg[BB-1], modulus_reg);
    assign mul_step = mulred_step(work_reg, mul_b_reg[MB-1], mul_a_reg, modulus_reg);
    assign acc_init = (modulus_reg == MB'(1)) ? '0 : MB'(1);

    assign s_tready = (state_reg == modexp_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = modexp_pkg::OUT_DATA_W'(res_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= modexp_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            modulus_reg  <= modexp_pkg::MODULUS_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                modulus_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        base_sr_reg  <= base_sr_next;
        exp_sr_reg   <= exp_sr_next;
        base_red_reg <= base_red_next;
        acc_reg      <= acc_next;
        work_reg     <= work_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        scan_cnt_reg <= scan_cnt_next;
        mul_cnt_reg  <= mul_cnt_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        res_next      = res_reg;
        base_sr_next  = base_sr_reg;
        exp_sr_next   = exp_sr_reg;
        base_red_next = base_red_reg;
        acc_next      = acc_reg;
        work_next     = work_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        scan_cnt_next = scan_cnt_reg;
        mul_cnt_next  = mul_cnt_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg) inside
            modexp_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    base_sr_next  = s_tdata[BB-1:0];
                    exp_sr_next   = s_tdata[BB+EB-1:BB];
                    base_red_next = '0;
                    scan_cnt_next = SW'(BB - 1);
                    if (modulus_reg == '0)
                    begin
                        acc_next   = '0;
                        state_next = modexp_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = modexp_pkg::ST_REDUCE;
                    end
                end
            end

            modexp_pkg::ST_REDUCE:
            begin
                base_red_next = red_step;
                base_sr_next  = base_sr_reg << 1;
                scan_cnt_next = scan_cnt_reg - SW'(1);
                if (scan_cnt_reg == '0)
                begin
                    acc_next      = acc_init;
                    mul_a_next    = acc_init;
                    mul_b_next    = acc_init;
                    work_next     = '0;
                    mul_cnt_next  = MW'(MB - 1);
                    scan_cnt_next = SW'(EB - 1);
                    state_next    = modexp_pkg::ST_SQUARE;
                end
            end

            modexp_pkg::ST_SQUARE,
            modexp_pkg::ST_MULT:
            begin
                work_next    = mul_step;
                mul_b_next   = mul_b_reg << 1;
                mul_cnt_next = mul_cnt_reg - MW'(1);
                if (mul_cnt_reg == '0)
                begin
                    acc_next     = mul_step;
                    work_next    = '0;
                    mul_cnt_next = MW'(MB - 1);
                    if (state_reg == modexp_pkg::ST_SQUARE && exp_sr_reg[EB-1])
                    begin
                        mul_a_next = base_red_reg;
                        mul_b_next = mul_step;
                        state_next = modexp_pkg::ST_MULT;
                    end
                    else
                    begin
                        exp_sr_next = exp_sr_reg << 1;
                        if (scan_cnt_reg == '0)
                        begin
                            state_next = modexp_pkg::ST_DONE;
                        end
                        else
                        begin
                            scan_cnt_next = scan_cnt_reg - SW'(1);
                            mul_a_next    = mul_step;
                            mul_b_next    = mul_step;
                            state_next    = modexp_pkg::ST_SQUARE;
                        end
                    end
                end
            end

            modexp_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    res_next      = acc_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = modexp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = modexp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> bench/modular_exponentiation_unit_tb.sv
module modular_exponentiation_unit_tb;

    typedef logic [modexp_pkg::BASE_BITS-1:0]     base_t;
    typedef logic [modexp_pkg::EXPONENT_BITS-1:0] expo_t;
    typedef logic [modexp_pkg::MODULUS_BITS-1:0]  residue_t;

    typedef struct packed {
        base_t    base;
        expo_t    expo;
        residue_t residue;
    } power_case_t;

    localparam base_t    BASE_MAX    = '1;
    localparam expo_t    EXPO_MAX    = '1;
    localparam residue_t MODULUS_MAX = '1;

    logic                                  clk       = 1'b0;
    logic                                  rst_n     = 1'b0;
    logic                                  cfg_we    = 1'b0;
    logic [modexp_pkg::MODULUS_BITS-1:0]   cfg_wdata = '0;
    logic                                  s_tvalid  = 1'b0;
    logic                                  s_tready;
    logic [modexp_pkg::IN_DATA_W-1:0]      s_tdata   = '0;    // base_value, exponent
    logic                                  m_tvalid;
    logic                                  m_tready  = 1'b0;
    logic [modexp_pkg::OUT_DATA_W-1:0]     m_tdata;           // power_residue

    power_case_t expected_residues[$];
    residue_t    modulus_setting = modexp_pkg::MODULUS_RESET;
    bit          no_gaps = 1'b0;
    int          output_hold_cycles = 0;
    int          error_count = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          modulus_writes = 0;

    modular_exponentiation_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // left-to-right square-and-multiply over all exponent bits
    function automatic residue_t predict_power_residue(base_t base, expo_t expo, residue_t m);
        logic [63:0] acc;
        logic [63:0] b;
        logic [63:0] m64;
        int          i;
        if (m == '0)
            return '0;
        m64 = 64'(m);
        acc = 64'd1 % m64;
        b   = 64'(base) % m64;
        for (i = modexp_pkg::EXPONENT_BITS - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % m64;
            if (expo[i])
                acc = (acc * b) % m64;
        end
        return residue_t'(acc);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [62:0] rand63();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0];
    endfunction

    function automatic base_t random_base(residue_t m);
        logic [63:0] prod;
        case ($urandom_range(0, 9)) inside
            [0:3]: return rand63();
            [4:5]: return (m == '0) ? base_t'($urandom) : base_t'($urandom_range(0, m - 1));
            [6:7]:
            begin
                // multiples of the modulus, slightly offset
                prod = 64'($urandom) * 64'(m) + 64'($urandom_range(0, 3));
                return prod[62:0];
            end
            8: return base_t'($urandom_range(0, 1));
            default: return ($urandom_range(0, 1) != 0) ? BASE_MAX : base_t'(m) - 1;
        endcase
    endfunction

    function automatic expo_t random_exponent();
        case ($urandom_range(0, 9)) inside
            [0:4]: return rand63();
            [5:6]: return expo_t'($urandom_range(0, 20));
            7: return EXPO_MAX;
            8: return expo_t'(1) << $urandom_range(0, modexp_pkg::EXPONENT_BITS - 1);
            default: return rand63() >> $urandom_range(0, modexp_pkg::EXPONENT_BITS - 1);
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // leaves s_tvalid high on return; a drain or a gapped send lowers it
    task automatic send_item(base_t base, expo_t expo);
        power_case_t item;
        int          gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= modexp_pkg::IN_DATA_W'({expo, base});
        do
            @(posedge clk);
        while (!s_tready);
        item.base    = base;
        item.expo    = expo;
        item.residue = predict_power_residue(base, expo, modulus_setting);
        expected_residues = {expected_residues, item};
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_residues.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_modulus(residue_t value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        modulus_setting = value;
        modulus_writes++;
    endtask

    task automatic test_reset_modulus();
        send_item(base_t'(2), expo_t'(10));
        send_item(base_t'(0), expo_t'(0));
        send_item(base_t'(0), expo_t'(5));
        send_item(BASE_MAX, EXPO_MAX);
        send_item(base_t'(1000000007), expo_t'(3));
        send_item(base_t'(1000000006), expo_t'(2));
        send_item(base_t'(7), expo_t'(1));
        send_item(BASE_MAX, expo_t'(1));
        send_item(base_t'(3), expo_t'(1) << (modexp_pkg::EXPONENT_BITS - 1));
        drain_results();
    endtask

    task automatic test_modulus_extremes();
        write_modulus(residue_t'(1));
        send_item(base_t'(5), expo_t'(0));
        send_item(BASE_MAX, EXPO_MAX);
        write_modulus(MODULUS_MAX);
        send_item(base_t'(MODULUS_MAX) - 1, EXPO_MAX);
        send_item(BASE_MAX, expo_t'(2));
        send_item(base_t'(MODULUS_MAX), expo_t'(5));
        send_item(base_t'(0), expo_t'(0));
        write_modulus(residue_t'(2));
        send_item(base_t'(3), expo_t'(7));
        send_item(base_t'(4), expo_t'(0));
        // zero modulus has no residue class, result is 0
        write_modulus(residue_t'(0));
        send_item(base_t'(3), expo_t'(4));
        send_item(base_t'(0), expo_t'(0));
        send_item(BASE_MAX, expo_t'(1));
        drain_results();
    endtask

    task automatic test_back_to_back();
        no_gaps = 1'b1;
        write_modulus(residue_t'($urandom_range(1, MODULUS_MAX)));
        repeat (6) send_item(random_base(modulus_setting), random_exponent());
        drain_results();
        no_gaps = 1'b0;
    endtask

    task automatic test_output_backpressure();
        // result stays parked long enough for the input side to stall
        output_hold_cycles = 12000;
        repeat (5) send_item(random_base(modulus_setting), random_exponent());
        drain_results();
    endtask

    task automatic test_random_items();
        int phase;
        residue_t m;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: m = residue_t'($urandom_range(1, MODULUS_MAX));
                1: m = residue_t'($urandom_range(1, 255));
                2: m = MODULUS_MAX;
                3: m = residue_t'(1) << $urandom_range(1, modexp_pkg::MODULUS_BITS - 1);
                4: m = residue_t'($urandom_range(32'h4000_0000, MODULUS_MAX));
                default: m = residue_t'($urandom_range(2, 65535));
            endcase
            write_modulus(m);
            repeat (18) send_item(random_base(modulus_setting), random_exponent());
        end
        drain_results();
    endtask

    initial
    begin : result_sink
        int          stall_left;
        power_case_t want;
        residue_t    got;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[modexp_pkg::MODULUS_BITS-1:0];
                if (expected_residues.size() == 0)
                    report_mismatch($sformatf("unexpected result %0d", got));
                else
                begin
                    want = expected_residues.pop_front();
                    results_checked++;
                    if (got !== want.residue)
                        report_mismatch($sformatf(
                            "base %0d exp %0d: power_residue %0d, want %0d",
                            want.base, want.expo, got, want.residue));
                end
            end
            if (output_hold_cycles > 0)
            begin
                output_hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("Timeout with %0d results outstanding", expected_residues.size());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_modulus();
        test_modulus_extremes();
        test_back_to_back();
        test_output_backpressure();
        test_random_items();
        drain_results();
        // anything arriving now has no matching item
        repeat (4000) @(posedge clk);
        $display("Sent %0d items, checked %0d residues across %0d modulus writes",
                 items_sent, results_checked, modulus_writes);
        $display("Moduli covered reset value, 0, 1, 2, powers of two and 2^31-1");
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
design/modexp_pkg.sv
design/modular_exponentiation_unit.sv
bench/modular_exponentiation_unit_tb.sv
